@@ rtl/core/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the ARP neighbor cache.
// ----------------------------------------------------------------------------
package arp_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_LEARN  = 2'd1,
    KIND_SWEEP  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_UPDATED  = 3'd0,
    OUT_INSERTED = 3'd1,
    OUT_REPLACED = 3'd2,
    OUT_DROPPED  = 3'd3,
    OUT_OTHER    = 3'd4
  } outcome_t;

  localparam logic [31:0] BCAST_IP   = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MCAST_IP   = {8'd224, 16'd0, 8'd22};
  localparam logic [47:0] MCAST_MAC  = {8'h01, 8'h00, 8'h5E, 8'h00, 8'h00, 8'h16};
  localparam logic [31:0] STALE_RESET = 32'd30099;

  // one queued request
  typedef struct packed {
    kind_t       kind;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic        make_permanent;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_found;
    outcome_t    outcome;
    logic [5:0]  slot;
    logic [6:0]  removed_count;
  } rsp_t;

endpackage

@@ rtl/core/arp_ram.sv @@
// ----------------------------------------------------------------------------
// arp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, returns the old word on a write
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/arp_front.sv @@
// ----------------------------------------------------------------------------
// arp_front
// Input side: classifies items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module arp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  arp_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_ready,
  output arp_pkg::req_t q_req
);
  import arp_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;
  req_t       cls;

  // fold unknown kinds into one code
  always_comb begin
    cls = in_req;
    if (in_req.kind != KIND_LOOKUP && in_req.kind != KIND_LEARN &&
        in_req.kind != KIND_SWEEP) cls.kind = KIND_NONE;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = buf_q[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= cls;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ rtl/core/arp_back.sv @@
// ----------------------------------------------------------------------------
// arp_back
// Execution side: scans the table one entry per cycle and applies the item.
// ----------------------------------------------------------------------------
module arp_back #(
  parameter int ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  arp_pkg::req_t q_req,
  input  logic [31:0]   stale_limit,
  output logic          out_valid,
  input  logic          out_ready,
  output arp_pkg::rsp_t out_rsp
);
  import arp_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_DEC   = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;
  req_t   req;
  logic [ENTRIES-1:0] valid, perm;
  logic [AW-1:0] idx, idx_d;
  logic          rd_live;
  // scan results
  logic          found, free_seen, old_seen;
  logic [AW-1:0] found_idx, free_idx, old_idx;
  logic [31:0]   old_time;
  logic [47:0]   found_mac;
  logic [CW-1:0] removed;
  logic [AW-1:0] tgt;
  // RAM port
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   ip_rd, time_rd;
  logic [47:0]   mac_rd;
  logic [31:0]   ip_wr, time_wr;
  logic [47:0]   mac_wr;
  logic [31:0]   age;
  logic          seed;
  logic [AW-1:0] seed_idx;
  rsp_t          rsp_next;

  // reset seeds entries 0 and 1, one per cycle, before the first item
  always_comb begin
    we = 1'b0;
    addr = idx;
    ip_wr = req.ip_address;
    mac_wr = req.mac_address;
    time_wr = req.current_time;
    if (seed) begin
      we = 1'b1;
      addr = seed_idx;
      time_wr = '0;
      ip_wr = (seed_idx == '0) ? BCAST_IP : MCAST_IP;
      mac_wr = (seed_idx == '0) ? BCAST_MAC : MCAST_MAC;
    end else if (state == S_WRITE && (found || free_seen || old_seen)) begin
      we = 1'b1;
      addr = tgt;
    end
  end

  arp_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ip (
    .clk(clk), .we(we && (seed || !found)), .addr(addr), .wdata(ip_wr), .rdata(ip_rd));
  arp_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_mac (
    .clk(clk), .we(we), .addr(addr), .wdata(mac_wr), .rdata(mac_rd));
  arp_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_time (
    .clk(clk), .we(we), .addr(addr), .wdata(time_wr), .rdata(time_rd));

  assign age = req.current_time - time_rd;
  assign q_ready = (state == S_IDLE) && !seed;
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid && !seed) begin
        state_next = (q_req.kind == KIND_NONE) ? S_DEC : S_SCAN;
      end
      S_SCAN:  if (idx == AW'(ENTRIES - 1)) state_next = S_LAST;
      S_LAST:  state_next = S_DEC;
      S_DEC:   state_next = (req.kind == KIND_LEARN) ? S_WRITE : S_OUT;
      S_WRITE: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seed <= 1'b1;
      seed_idx <= '0;
      valid <= ENTRIES'(3);
      perm <= ENTRIES'(3);
    end else begin
      state <= state_next;
      if (seed) begin
        seed_idx <= seed_idx + 1'b1;
        if (seed_idx == AW'(1)) seed <= 1'b0;
      end
      // sweep: drop stale entries as their data comes back
      if (rd_live && req.kind == KIND_SWEEP && valid[idx_d] && !perm[idx_d] &&
          age > stale_limit) valid[idx_d] <= 1'b0;
      if (state == S_WRITE && (found || free_seen || old_seen)) begin
        valid[tgt] <= 1'b1;
        if (!found) perm[tgt] <= req.make_permanent;
        else if (req.make_permanent) perm[tgt] <= 1'b1;
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    rd_live <= (state == S_SCAN);
    idx_d <= idx;
    if (state == S_IDLE) begin
      req <= q_req;
      idx <= '0;
      found <= 1'b0;
      free_seen <= 1'b0;
      old_seen <= 1'b0;
      old_time <= '1;
      removed <= '0;
      found_idx <= '0;
      free_idx <= '0;
      old_idx <= '0;
      found_mac <= '0;
    end else begin
      if (state == S_SCAN) idx <= idx + 1'b1;
      if (rd_live) begin
        if (valid[idx_d] && ip_rd == req.ip_address && !found) begin
          found <= 1'b1;
          found_idx <= idx_d;
          found_mac <= mac_rd;
        end
        if (!valid[idx_d] && !free_seen) begin
          free_seen <= 1'b1;
          free_idx <= idx_d;
        end
        if (valid[idx_d] && !perm[idx_d] && !free_seen && time_rd <= old_time) begin
          old_seen <= 1'b1;
          old_idx <= idx_d;
          old_time <= time_rd;
        end
        if (req.kind == KIND_SWEEP && valid[idx_d] && !perm[idx_d] &&
            age > stale_limit) removed <= removed + 1'b1;
      end
    end
  end

  assign tgt = found ? found_idx : (free_seen ? free_idx : old_idx);

  // build result
  always_comb begin
    rsp_next = '0;
    rsp_next.outcome = OUT_OTHER;
    unique case (req.kind)
      KIND_LOOKUP: if (found) begin
        rsp_next.hit = 1'b1;
        rsp_next.mac_found = found_mac;
        rsp_next.slot = 6'(found_idx);
      end
      KIND_LEARN: begin
        rsp_next.slot = (found || free_seen || old_seen) ? 6'(tgt) : 6'd0;
        rsp_next.outcome = found ? OUT_UPDATED : free_seen ? OUT_INSERTED :
                           old_seen ? OUT_REPLACED : OUT_DROPPED;
      end
      KIND_SWEEP: rsp_next.removed_count = 7'(removed);
      KIND_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DEC) out_rsp <= rsp_next;
  end
endmodule

@@ rtl/core/arp_neighbor_cache_unit.sv @@
// ----------------------------------------------------------------------------
// arp_neighbor_cache_unit
// IPv4-to-MAC neighbor cache with scan-based lookup, learn and sweep.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 content
// s_axis    in   s_axis_tvalid/tready      request item
// m_axis    out  m_axis_tvalid/tready      result item
// cfg       in   cfg_valid/cfg_ready       stale_limit
//
// A lookup or sweep makes one pass over the table RAMs, one entry per cycle
// through their single ports, and a learn adds a write step after the pass.
// An unknown kind skips the scan. After reset the two fixed entries are written
// before the first item starts. The input queue takes two items while the
// scanner or the output is stalled.
module arp_neighbor_cache_unit #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ip_address[31:0], mac_address[79:32], make_permanent[80], current_time[112:81]
  input  logic [119:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], mac_found[48:1], slot[54:49], removed_count[61:55]
  output logic [63:0]  m_axis_tdata,
  // outcome[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import arp_pkg::*;

  req_t       in_req, q_req;
  rsp_t       rsp;
  logic       q_valid, q_ready;
  logic [31:0] stale_limit;

  assign in_req.kind = kind_t'(s_axis_tuser);
  assign in_req.ip_address = s_axis_tdata[31:0];
  assign in_req.mac_address = s_axis_tdata[79:32];
  assign in_req.make_permanent = s_axis_tdata[80];
  assign in_req.current_time = s_axis_tdata[112:81];

  // hold the stale limit
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) stale_limit <= STALE_RESET;
    else if (cfg_valid) stale_limit <= cfg_data;
  end

  arp_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

  arp_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .stale_limit(stale_limit), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_rsp(rsp));

  assign m_axis_tdata = {2'b00, rsp.removed_count, rsp.slot, rsp.mac_found, rsp.hit};
  assign m_axis_tuser = rsp.outcome;
endmodule
